/* hw/rtl/cht_pkg.sv */
package cht_pkg;

    localparam int MaxBuckets = 256;
    localparam int PoolNodes  = 256;
    localparam int BktW       = 8;
    localparam int NodeW      = 8;
    localparam int PtrW       = 9;
    localparam int FifoDepth  = 2;

    // Command codes.
    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_LOOKUP = 3'd1,
        CMD_COUNT  = 3'd2,
        CMD_NEXT   = 3'd3,
        CMD_REWIND = 3'd4
    } t_cmd;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_END      = 2'd3;

    // Classified operation passed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_INSERT,
        OP_FULL,
        OP_LOOKUP,
        OP_NEXT,
        OP_REWIND,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [BktW-1:0]  bucket;
        logic [31:0]      key;
        logic [31:0]      value;
    } t_job;

    typedef enum logic [3:0] {
        BE_IDLE,
        BE_INS_HEAD,
        BE_INS_LINK,
        BE_LK_HEAD,
        BE_LK_READ,
        BE_LK_CHECK,
        BE_IT_SCAN,
        BE_IT_READ,
        BE_IT_OUT,
        BE_DONE
    } t_be_state;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_DIV,
        FE_PUSH
    } t_fe_state;

endpackage

/* hw/rtl/cht_front.sv */
// Front end: takes commands, reduces keys to a bucket index with a
// restoring divider (one quotient bit per cycle), and queues jobs.
module cht_front import cht_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_key,
    input  logic [31:0] i_value,
    input  logic [8:0]  i_bc,
    input  logic        i_clear,
    input  logic        i_full_room,
    output logic        o_idle,
    output logic        o_push,
    output t_job        o_job
);

    t_fe_state   r_state, n_state;
    t_job        r_job;
    logic [8:0]  r_rem;
    logic [31:0] r_dvd;
    logic [5:0]  r_cnt;
    logic [8:0]  r_used;
    logic [9:0]  w_trial;
    logic [8:0]  w_div;

    assign w_div   = (i_bc == 9'd0) ? 9'd1 : ((i_bc > 9'd256) ? 9'd256 : i_bc);
    assign w_trial = {r_rem, r_dvd[31]};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            FE_IDLE: if (i_start) begin
                n_state = (t_cmd'(i_command) == CMD_INSERT
                           || t_cmd'(i_command) == CMD_LOOKUP) ? FE_DIV : FE_PUSH;
                if (t_cmd'(i_command) == CMD_INSERT && r_used == 9'(PoolNodes))
                    n_state = FE_PUSH;
            end
            FE_DIV: if (r_cnt == 6'd31) n_state = FE_PUSH;
            FE_PUSH: if (i_full_room) n_state = FE_IDLE;
            default: n_state = FE_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_idle = (r_state == FE_IDLE);
        o_push = (r_state == FE_PUSH) && i_full_room;
        o_job  = r_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state <= FE_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            if (o_push && r_job.op == OP_INSERT) r_used <= r_used + 9'd1;
        end
        case (r_state)
            FE_IDLE: begin
                r_job.key   <= i_key;
                r_job.value <= i_value;
                r_dvd       <= i_key;
                r_rem       <= '0;
                r_cnt       <= '0;
                case (t_cmd'(i_command))
                    CMD_INSERT: r_job.op <= (r_used == 9'(PoolNodes)) ? OP_FULL : OP_INSERT;
                    CMD_LOOKUP: r_job.op <= OP_LOOKUP;
                    CMD_NEXT:   r_job.op <= OP_NEXT;
                    CMD_REWIND: r_job.op <= OP_REWIND;
                    default:    r_job.op <= OP_NOP;
                endcase
            end
            FE_DIV: begin
                r_dvd <= {r_dvd[30:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
                if (w_trial >= {1'b0, w_div}) r_rem <= 9'(w_trial - {1'b0, w_div});
                else r_rem <= w_trial[8:0];
                if (r_cnt == 6'd31) begin
                    if (w_trial >= {1'b0, w_div})
                        r_job.bucket <= BktW'(w_trial - {1'b0, w_div});
                    else
                        r_job.bucket <= w_trial[BktW-1:0];
                end
            end
            default: ;
        endcase
    end

endmodule

/* hw/rtl/cht_fifo.sv */
// Two-entry job queue between front and back end.
module cht_fifo import cht_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_clear,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_room,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [FifoDepth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_room  = (r_cnt != 2'(FifoDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_job;
    end

endmodule

/* hw/rtl/cht_back.sv */
// Back end: owns the table memories and carries out one job at a time.
module cht_back import cht_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic [8:0]  i_bc,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_idle,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [31:0] o_found_key,
    output logic [31:0] o_found_value,
    output logic [8:0]  o_item_count
);

    logic [NodeW-1:0] m_head  [MaxBuckets];
    logic [NodeW-1:0] m_tail  [MaxBuckets];
    logic [31:0]      m_key   [PoolNodes];
    logic [31:0]      m_val   [PoolNodes];
    logic [PtrW-1:0]  m_next  [PoolNodes];
    logic [MaxBuckets-1:0] r_bvalid;

    t_be_state        r_state, n_state;
    t_job             r_job;
    logic [8:0]       r_used;
    logic [8:0]       r_ibkt;
    logic [PtrW-1:0]  r_inode;
    logic [NodeW-1:0] r_tail_q, r_node;
    logic [31:0]      r_rkey, r_rval;
    logic [PtrW-1:0]  r_rnext;
    logic [1:0]       r_status;
    logic [31:0]      r_okey, r_oval;
    logic             r_done;
    logic [8:0]       w_bc;
    logic             w_inode_null;

    assign w_bc         = (i_bc == 9'd0) ? 9'd1 : ((i_bc > 9'd256) ? 9'd256 : i_bc);
    assign w_inode_null = r_inode[PtrW-1];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BE_IDLE: if (i_valid) begin
                case (i_job.op)
                    OP_INSERT: n_state = BE_INS_HEAD;
                    OP_LOOKUP: n_state = BE_LK_HEAD;
                    OP_NEXT:   n_state = BE_IT_SCAN;
                    default:   n_state = BE_DONE;
                endcase
            end
            BE_INS_HEAD: n_state = BE_INS_LINK;
            BE_INS_LINK: n_state = BE_DONE;
            BE_LK_HEAD:  n_state = r_bvalid[r_job.bucket] ? BE_LK_READ : BE_DONE;
            BE_LK_READ:  n_state = BE_LK_CHECK;
            BE_LK_CHECK: begin
                if (r_rkey == r_job.key || r_rnext[PtrW-1]) n_state = BE_DONE;
                else n_state = BE_LK_READ;
            end
            BE_IT_SCAN: begin
                if (!w_inode_null) n_state = BE_IT_READ;
                else if (r_ibkt >= w_bc) n_state = BE_DONE;
                else if (r_bvalid[r_ibkt[BktW-1:0]]) n_state = BE_IT_READ;
            end
            BE_IT_READ: n_state = BE_IT_OUT;
            BE_IT_OUT:  n_state = BE_DONE;
            BE_DONE:    n_state = BE_IDLE;
            default:    n_state = BE_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_pop         = (r_state == BE_IDLE) && i_valid;
        o_idle        = (r_state == BE_IDLE) && !i_valid;
        o_done        = r_done;
        o_status      = r_status;
        o_found_key   = r_okey;
        o_found_value = r_oval;
        o_item_count  = r_used;
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        r_tail_q <= m_tail[r_job.bucket];
        r_rkey   <= m_key[r_node];
        r_rval   <= m_val[r_node];
        r_rnext  <= m_next[r_node];
        if (r_state == BE_INS_HEAD) begin
            m_key[r_used[NodeW-1:0]]  <= r_job.key;
            m_val[r_used[NodeW-1:0]]  <= r_job.value;
            m_next[r_used[NodeW-1:0]] <= PtrW'(PoolNodes);
            m_tail[r_job.bucket]      <= r_used[NodeW-1:0];
            if (!r_bvalid[r_job.bucket]) m_head[r_job.bucket] <= r_used[NodeW-1:0];
        end
        if (r_state == BE_INS_LINK && r_bvalid[r_job.bucket] && r_tail_q != r_used[NodeW-1:0])
            m_next[r_tail_q] <= {1'b0, r_used[NodeW-1:0]};
    end

    // Control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state  <= BE_IDLE;
            r_bvalid <= '0;
            r_used   <= '0;
            r_ibkt   <= '0;
            r_inode  <= PtrW'(PoolNodes);
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == BE_DONE);
            case (r_state)
                BE_IDLE: if (i_valid) begin
                    r_job    <= i_job;
                    r_status <= (i_job.op == OP_FULL) ? ST_FULL
                              : (i_job.op == OP_LOOKUP) ? ST_NOTFOUND : ST_OK;
                    r_okey   <= '0;
                    r_oval   <= '0;
                    if (i_job.op == OP_REWIND) begin
                        r_ibkt  <= '0;
                        r_inode <= PtrW'(PoolNodes);
                    end
                end
                // The node count advances only after the tail link used it.
                BE_INS_LINK: begin
                    r_bvalid[r_job.bucket] <= 1'b1;
                    r_used <= r_used + 9'd1;
                end
                BE_LK_HEAD:  r_node <= m_head[r_job.bucket];
                BE_LK_CHECK: begin
                    if (r_rkey == r_job.key) begin
                        r_status <= ST_OK;
                        r_okey   <= r_rkey;
                        r_oval   <= r_rval;
                    end else begin
                        r_node <= r_rnext[NodeW-1:0];
                    end
                end
                BE_IT_SCAN: begin
                    if (!w_inode_null) r_node <= r_inode[NodeW-1:0];
                    else if (r_ibkt >= w_bc) begin
                        r_status <= ST_END;
                        r_ibkt   <= '0;
                    end else if (r_bvalid[r_ibkt[BktW-1:0]]) begin
                        r_node <= m_head[r_ibkt[BktW-1:0]];
                    end else r_ibkt <= r_ibkt + 9'd1;
                end
                BE_IT_OUT: begin
                    r_okey <= r_rkey;
                    r_oval <= r_rval;
                    if (!r_rnext[PtrW-1]) r_inode <= r_rnext;
                    else begin
                        r_inode <= PtrW'(PoolNodes);
                        r_ibkt  <= r_ibkt + 9'd1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* hw/rtl/chained_hash_table_core.sv */
// Chained hash table over a 256-node pool. Pulse i_start with a command
// while o_busy is low; each command gives exactly one result word on the
// o_ ports, marked by o_done for one cycle, which the receiver must take
// then since it cannot stall. Insert and lookup run the key through the
// front-end key divider (one quotient bit a cycle), but an insert into a
// full pool skips it; o_busy stays high until the front end has queued the
// job, which waits while the queue is full. A lookup walks the bucket's
// chain node by node; iterate-next skips empty buckets one at a time.
// A two-word queue between front and back end lets a new command be
// accepted while the previous one finishes.
// Writing i_cfg_we empties the table and rewinds the iterator at once.
module chained_hash_table_core import cht_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_key,
    input  logic [31:0] i_value,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [31:0] o_found_key,
    output logic [31:0] o_found_value,
    output logic [8:0]  o_item_count
);

    logic [8:0] r_bc;
    logic       w_fe_idle, w_push, w_room, w_valid, w_pop, w_be_idle;
    t_job       w_job_in, w_job_out;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bc <= 9'(MaxBuckets);
        else if (i_cfg_we) r_bc <= i_cfg_wdata;
    end

    // Busy until the front end is free again.
    assign o_busy = !w_fe_idle;

    cht_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
        .i_command(i_command), .i_key(i_key), .i_value(i_value),
        .i_bc(r_bc), .i_clear(i_cfg_we), .i_full_room(w_room),
        .o_idle(w_fe_idle), .o_push(w_push), .o_job(w_job_in)
    );

    cht_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(i_cfg_we),
        .i_push(w_push), .i_job(w_job_in), .i_pop(w_pop),
        .o_room(w_room), .o_valid(w_valid), .o_job(w_job_out)
    );

    cht_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(i_cfg_we), .i_bc(r_bc),
        .i_valid(w_valid), .i_job(w_job_out), .o_pop(w_pop), .o_idle(w_be_idle),
        .o_done(o_done), .o_status(o_status), .o_found_key(o_found_key),
        .o_found_value(o_found_value), .o_item_count(o_item_count)
    );

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_room) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_valid) else $error("pop from empty queue");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result held two cycles");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_be_idle |=> !o_done) else $error("result without job");
`endif

endmodule
